// ===== rtl/button_debounce_click_hold_macros.svh =====
// assertion helpers for the button debouncer checker
`ifndef BUTTON_DEBOUNCE_CLICK_HOLD_MACROS_SVH
`define BUTTON_DEBOUNCE_CLICK_HOLD_MACROS_SVH

// same-cycle implication, sampled on clk, quiet during reset
`define BDCH_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bdch check failed");

// next-cycle implication, sampled on clk, quiet during reset
`define BDCH_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bdch check failed");

`endif

// ===== rtl/bdch_pkg.sv =====
package bdch_pkg;

  localparam int TimeW   = 32;
  localparam int CfgW    = 16;
  localparam int CntW    = 32;
  localparam int CfgIdxW = 2;

  typedef logic [CfgIdxW-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_DEBOUNCE  = 2'd0;
  localparam cfg_idx_t REG_DBL_WIN   = 2'd1;
  localparam cfg_idx_t REG_HOLD_THR  = 2'd2;

  typedef struct packed {
    logic [CfgW-1:0] hold_threshold_ms;
    logic [CfgW-1:0] double_click_window_ms;
    logic [CfgW-1:0] debounce_ms;
  } cfg_t;

  // last field in the lowest bits
  typedef struct packed {
    logic             clear_count;
    logic [TimeW-1:0] now_ms;
    logic             raw_level;
  } item_t;

  typedef struct packed {
    logic [CntW-1:0]  press_total;
    logic [TimeW-1:0] hold_duration_ms;
    logic             held_flag;
    logic             double_click_event;
    logic             release_event;
    logic             press_event;
    logic             debounced_level;
  } result_t;

  localparam int ItemW    = $bits(item_t);
  localparam int ResW     = $bits(result_t);
  localparam int InDataW  = ((ItemW + 7) / 8) * 8;
  localparam int OutDataW = ((ResW + 7) / 8) * 8;

endpackage

// ===== rtl/bdch_cfg.sv =====
module bdch_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  bdch_pkg::cfg_idx_t           cfg_index,
  input  logic [bdch_pkg::CfgW-1:0]    cfg_wdata,
  output bdch_pkg::cfg_t               cfg
);

  bdch_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ms            <= bdch_pkg::CfgW'(50);
      cfg_r.double_click_window_ms <= bdch_pkg::CfgW'(500);
      cfg_r.hold_threshold_ms      <= bdch_pkg::CfgW'(1000);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        bdch_pkg::REG_DEBOUNCE: cfg_r.debounce_ms            <= cfg_wdata;
        bdch_pkg::REG_DBL_WIN:  cfg_r.double_click_window_ms <= cfg_wdata;
        bdch_pkg::REG_HOLD_THR: cfg_r.hold_threshold_ms      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/bdch_core.sv =====
module bdch_core (
  input  logic              clk,
  input  logic              rst_n,
  input  bdch_pkg::cfg_t    cfg,
  input  bdch_pkg::item_t   item,
  input  logic              advance,
  output bdch_pkg::result_t result
);

  logic                         stable_r, stable_nxt;
  logic [bdch_pkg::TimeW-1:0]   change_start_r, change_start_nxt;
  logic [bdch_pkg::TimeW-1:0]   last_press_r, last_press_nxt;
  logic [bdch_pkg::CntW-1:0]    press_cnt_r, press_cnt_nxt;
  logic                         held_r, held_nxt;

  logic [bdch_pkg::CntW-1:0]    cnt_base;
  logic [bdch_pkg::TimeW-1:0]   since_change, gap, hold;
  logic [bdch_pkg::TimeW-1:0]   deb_ext, win_ext, thr_ext;
  logic                         differ, take, press, release_ev, dbl;

  always_comb begin
    deb_ext = bdch_pkg::TimeW'(cfg.debounce_ms);
    win_ext = bdch_pkg::TimeW'(cfg.double_click_window_ms);
    thr_ext = bdch_pkg::TimeW'(cfg.hold_threshold_ms);

    cnt_base     = item.clear_count ? '0 : press_cnt_r;
    differ       = item.raw_level != stable_r;
    since_change = item.now_ms - change_start_r;
    take         = differ && (since_change >= deb_ext);

    stable_nxt       = take ? item.raw_level : stable_r;
    change_start_nxt = (!differ || take) ? item.now_ms : change_start_r;

    press      = take && item.raw_level;
    release_ev = take && !item.raw_level;
    gap        = item.now_ms - last_press_r;
    dbl        = press && (cnt_base != '0) && (gap <= win_ext) && (gap > deb_ext);

    last_press_nxt = press ? item.now_ms : last_press_r;
    press_cnt_nxt  = cnt_base + bdch_pkg::CntW'(press);

    // hold time is measured from the press time after this sample
    hold     = stable_nxt ? (item.now_ms - last_press_nxt) : '0;
    held_nxt = stable_nxt && (held_r || (hold >= thr_ext));

    result.debounced_level    = stable_nxt;
    result.press_event        = press;
    result.release_event      = release_ev;
    result.double_click_event = dbl;
    result.held_flag          = held_nxt;
    result.hold_duration_ms   = hold;
    result.press_total        = press_cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stable_r       <= 1'b0;
      change_start_r <= '0;
      last_press_r   <= '0;
      press_cnt_r    <= '0;
      held_r         <= 1'b0;
    end else if (advance) begin
      stable_r       <= stable_nxt;
      change_start_r <= change_start_nxt;
      last_press_r   <= last_press_nxt;
      press_cnt_r    <= press_cnt_nxt;
      held_r         <= held_nxt;
    end
  end

endmodule

// ===== rtl/button_debounce_click_hold.sv =====
// button debouncer with press, release, double-click and hold detection
// path: a transferred sample is registered in item_r, and its result is registered in res_r, which drives out_*
// throughput: one sample per cycle while out_tready allows; the state update of one sample feeds the next
// through a single register stage, so back-to-back samples need no gap, but back-pressure on out_tready stalls them
// reset: synchronous, active low; clears pipeline valids and button state,
// loads config defaults (debounce 50, double-click window 500, hold 1000)
module button_debounce_click_hold (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // raw_level[0], now_ms[32:1], clear_count[33], zero pad above
  input  logic [bdch_pkg::InDataW-1:0]      in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // debounced_level[0], press_event[1], release_event[2], double_click_event[3],
  // held_flag[4], hold_duration_ms[36:5], press_total[68:37], zero pad above
  output logic [bdch_pkg::OutDataW-1:0]     out_tdata,
  input  logic                              cfg_wr_en,
  input  logic [bdch_pkg::CfgIdxW-1:0]      cfg_index,
  input  logic [bdch_pkg::CfgW-1:0]         cfg_wdata
);

  bdch_pkg::cfg_t    cfg;
  bdch_pkg::item_t   item_r;
  bdch_pkg::result_t result, res_r;
  logic              item_vld_r, out_vld_r;
  logic              advance;

  bdch_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  bdch_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .item    (item_r),
    .advance (advance),
    .result  (result)
  );

  // item moves into the result register when that slot is free or being taken
  assign advance   = item_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !item_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      if (in_tready) begin
        item_vld_r <= in_tvalid;
      end
      if (advance) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r <= in_tdata[bdch_pkg::ItemW-1:0];
    end
    if (advance) begin
      res_r <= result;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{(bdch_pkg::OutDataW - bdch_pkg::ResW){1'b0}}, res_r};

endmodule

// ===== rtl/bdch_checker.sv =====
`include "button_debounce_click_hold_macros.svh"

module bdch_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [bdch_pkg::OutDataW-1:0] out_tdata
);

  bdch_pkg::result_t res;

  assign res = out_tdata[bdch_pkg::ResW-1:0];

  // a press and a release are never confirmed by the same sample
  `BDCH_ASSERT_NOW(a_press_release_excl, out_tvalid, !(res.press_event && res.release_event))

  // events agree with the debounced level they produced
  `BDCH_ASSERT_NOW(a_event_level, out_tvalid && (res.press_event || res.release_event),
    res.debounced_level == res.press_event)

  // a double-click only comes with a press
  `BDCH_ASSERT_NOW(a_dbl_needs_press, out_tvalid && res.double_click_event, res.press_event)

  // released button reports no hold
  `BDCH_ASSERT_NOW(a_released_no_hold, out_tvalid && !res.debounced_level,
    !res.held_flag && (res.hold_duration_ms == '0))

  // a stalled result keeps its payload
  `BDCH_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

endmodule

bind button_debounce_click_hold bdch_checker u_bdch_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== bench/tb_button_debounce_click_hold.sv =====
module tb_button_debounce_click_hold;
  import bdch_pkg::*;

  localparam int StallLimit = 4000;
  localparam cfg_idx_t REG_UNUSED = 2'd3;

  typedef enum logic [1:0] {RX_OPEN, RX_SPARSE, RX_PERIODIC, RX_COIN} rx_mode_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  // raw_level[0], now_ms[32:1], clear_count[33], zero pad above
  logic [InDataW-1:0]  in_tdata = '0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  // debounced_level[0], press_event[1], release_event[2], double_click_event[3],
  // held_flag[4], hold_duration_ms[36:5], press_total[68:37], zero pad above
  logic [OutDataW-1:0] out_tdata;
  logic                cfg_wr_en = 1'b0;
  cfg_idx_t            cfg_index = REG_DEBOUNCE;
  logic [CfgW-1:0]     cfg_wdata = '0;

  button_debounce_click_hold dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor copy of the debouncer
  logic [CfgW-1:0]  deb_ms = 16'd50;
  logic [CfgW-1:0]  win_ms = 16'd500;
  logic [CfgW-1:0]  hold_thr_ms = 16'd1000;
  logic             btn_level = 1'b0;
  logic [TimeW-1:0] btn_change_t = '0;
  logic [TimeW-1:0] btn_last_press = '0;
  logic [CntW-1:0]  btn_presses = '0;
  logic             btn_held = 1'b0;

  result_t          awaited_results[$];
  int unsigned      fault_count = 0;
  int unsigned      samples_sent = 0;
  int unsigned      burst_left = 0;
  int unsigned      step_hi = 40;
  logic [TimeW-1:0] now_track = '0;
  int unsigned      idle_cycles = 0;
  rx_mode_t         rx_mode = RX_OPEN;
  int unsigned      rx_left = 0;

  function automatic result_t debounce_step(item_t s);
    result_t          r;
    logic             was;
    logic [TimeW-1:0] since;
    logic [TimeW-1:0] gap;
    r = '0;
    was = btn_level;
    if (s.clear_count) btn_presses = '0;
    if (s.raw_level != btn_level) begin
      since = s.now_ms - btn_change_t;
      if (since >= TimeW'(deb_ms)) begin
        btn_level = s.raw_level;
        btn_change_t = s.now_ms;
        if (btn_level && !was) begin
          gap = s.now_ms - btn_last_press;
          r.press_event = 1'b1;
          if (btn_presses != 0 && gap <= TimeW'(win_ms) && gap > TimeW'(deb_ms))
            r.double_click_event = 1'b1;
          btn_last_press = s.now_ms;
          btn_presses = btn_presses + 1'b1;
        end
        if (!btn_level && was) begin
          r.release_event = 1'b1;
          btn_held = 1'b0;
        end
      end
    end else begin
      btn_change_t = s.now_ms;
    end
    if (btn_level) begin
      r.hold_duration_ms = s.now_ms - btn_last_press;
      if (r.hold_duration_ms >= TimeW'(hold_thr_ms)) btn_held = 1'b1;
    end else begin
      r.hold_duration_ms = '0;
      btn_held = 1'b0;
    end
    r.debounced_level = btn_level;
    r.held_flag = btn_held;
    r.press_total = btn_presses;
    return r;
  endfunction

  function automatic logic maybe_clear();
    return $urandom_range(0, 29) == 0;
  endfunction

  task automatic note_fault(input string what, input logic [31:0] want, input logic [31:0] got);
    fault_count++;
    if (fault_count <= 10)
      $display("mismatch %s: expected %0h, got %0h", what, want, got);
  endtask

  task automatic send_sample(input logic raw, input logic [TimeW-1:0] now, input logic clr);
    item_t s;
    s.raw_level = raw;
    s.now_ms = now;
    s.clear_count = clr;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      // a quarter of the bursts follow on with no gap at all
      if ($urandom_range(0, 3) != 0) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata <= {{(InDataW - ItemW){1'b0}}, s};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    awaited_results.push_back(debounce_step(s));
    burst_left--;
    samples_sent++;
    @(negedge clk);
  endtask

  task automatic sample_at(input logic raw, input int unsigned adv, input logic clr);
    now_track = now_track + adv;
    send_sample(raw, now_track, clr);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (awaited_results.size() != 0) @(negedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CfgW-1:0] v);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
    case (idx)
      REG_DEBOUNCE: deb_ms = v;
      REG_DBL_WIN:  win_ms = v;
      REG_HOLD_THR: hold_thr_ms = v;
      default: ;
    endcase
  endtask

  task automatic set_timing(input logic [CfgW-1:0] deb, input logic [CfgW-1:0] win,
                            input logic [CfgW-1:0] thr);
    wait_drained();
    write_reg(REG_DEBOUNCE, deb);
    write_reg(REG_DBL_WIN, win);
    write_reg(REG_HOLD_THR, thr);
  endtask

  // one press with contact bounce on both edges, then the released stretch
  task automatic click(input int unsigned down_ms, input int unsigned up_ms);
    int unsigned spent;
    int unsigned adv;
    repeat ($urandom_range(0, 4))
      sample_at(1'($urandom_range(0, 1)), $urandom_range(0, 3), maybe_clear());
    spent = 0;
    while (spent < down_ms) begin
      adv = $urandom_range(1, step_hi);
      sample_at(1'b1, adv, maybe_clear());
      spent += adv;
    end
    repeat ($urandom_range(0, 4))
      sample_at(1'($urandom_range(0, 1)), $urandom_range(0, 3), maybe_clear());
    spent = 0;
    while (spent < up_ms) begin
      adv = $urandom_range(1, step_hi);
      sample_at(1'b0, adv, maybe_clear());
      spent += adv;
    end
  endtask

  task automatic run_clicks(input int unsigned count);
    int unsigned stop_at;
    int unsigned down;
    int unsigned up;
    stop_at = samples_sent + count;
    while (samples_sent < stop_at) begin
      down = ($urandom_range(0, 3) == 0) ? $urandom_range(0, step_hi * 80)
                                         : $urandom_range(0, step_hi * 20);
      // short release gaps give double-click chances
      up = ($urandom_range(0, 1) == 0) ? $urandom_range(0, step_hi * 10)
                                       : $urandom_range(0, step_hi * 40);
      click(down, up);
      if ($urandom_range(0, 49) == 0) wait_drained();
    end
  endtask

  task automatic test_directed();
    send_sample(1'b0, 32'd0, 1'b0);
    send_sample(1'b1, 32'd10, 1'b0);
    send_sample(1'b1, 32'd60, 1'b0);
    send_sample(1'b1, 32'd1100, 1'b0);
    send_sample(1'b0, 32'd1120, 1'b0);
    send_sample(1'b0, 32'd1200, 1'b0);
    send_sample(1'b1, 32'd1210, 1'b0);
    send_sample(1'b1, 32'd1300, 1'b0);
    send_sample(1'b0, 32'd1360, 1'b0);
    send_sample(1'b1, 32'd1420, 1'b0);
    send_sample(1'b0, 32'd1480, 1'b1);
    send_sample(1'b1, 32'd1540, 1'b0);
    send_sample(1'b0, 32'd1600, 1'b0);
    // clear on the very sample that confirms a press
    send_sample(1'b1, 32'd1660, 1'b1);
    send_sample(1'b1, 32'hFFFF_FFF0, 1'b0);
    send_sample(1'b0, 32'hFFFF_FFFF, 1'b0);
    send_sample(1'b0, 32'd32, 1'b0);
    send_sample(1'b0, 32'd40, 1'b0);
    // time running backwards
    send_sample(1'b1, 32'd20, 1'b0);
    set_timing(16'd0, 16'hFFFF, 16'd0);
    write_reg(REG_UNUSED, 16'h0007);
    send_sample(1'b0, 32'd100, 1'b0);
    send_sample(1'b1, 32'd100, 1'b0);
    send_sample(1'b1, 32'd100, 1'b0);
    set_timing(16'hFFFF, 16'd0, 16'hFFFF);
    send_sample(1'b0, 32'd200, 1'b0);
    send_sample(1'b0, 32'd70000, 1'b0);
    send_sample(1'b1, 32'd70001, 1'b0);
    now_track = 32'd70001;
  endtask

  task automatic test_clicks();
    step_hi = 40;
    set_timing(16'd50, 16'd500, 16'd1000);
    run_clicks(400);
    set_timing(16'($urandom_range(0, 100)), 16'($urandom_range(100, 900)),
               16'($urandom_range(0, 1500)));
    run_clicks(400);
    step_hi = 25;
    set_timing(16'd20, 16'd300, 16'd400);
    run_clicks(300);
  endtask

  task automatic test_noise();
    set_timing(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
               16'($urandom_range(0, 65535)));
    for (int i = 0; i < 300; i++) begin
      if (i == 150)
        set_timing(16'($urandom_range(0, 200)), 16'($urandom_range(0, 65535)),
                   16'($urandom_range(0, 65535)));
      case ($urandom_range(0, 9))
        0: now_track = $urandom;
        1: now_track = now_track - $urandom_range(1, 200);
        2: ;
        default: now_track = now_track + $urandom_range(1, 80);
      endcase
      send_sample(1'($urandom_range(0, 1)), now_track, 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic test_extremes();
    step_hi = 10;
    set_timing(16'd0, 16'd0, 16'd0);
    run_clicks(150);
    step_hi = 9000;
    set_timing(16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_clicks(200);
  endtask

  // receiver back-pressure, switching pattern every so often
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 3));
      rx_left <= $urandom_range(10, 200);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_OPEN:     out_tready <= 1'b1;
      RX_SPARSE:   out_tready <= ($urandom_range(0, 3) != 0);
      RX_PERIODIC: out_tready <= (rx_left[1:0] == 2'd0);
      default:     out_tready <= 1'($urandom_range(0, 1));
    endcase
  end

  always @(posedge clk) begin : check_results
    result_t got;
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = result_t'(out_tdata[ResW-1:0]);
      if (awaited_results.size() == 0) begin
        note_fault("unexpected transfer, press_total", '0, got.press_total);
      end else begin
        want = awaited_results.pop_front();
        if (got.debounced_level != want.debounced_level)
          note_fault("debounced_level", 32'(want.debounced_level),
                     32'(got.debounced_level));
        if (got.press_event != want.press_event)
          note_fault("press_event", 32'(want.press_event), 32'(got.press_event));
        if (got.release_event != want.release_event)
          note_fault("release_event", 32'(want.release_event), 32'(got.release_event));
        if (got.double_click_event != want.double_click_event)
          note_fault("double_click_event", 32'(want.double_click_event),
                     32'(got.double_click_event));
        if (got.held_flag != want.held_flag)
          note_fault("held_flag", 32'(want.held_flag), 32'(got.held_flag));
        if (got.hold_duration_ms != want.hold_duration_ms)
          note_fault("hold_duration_ms", want.hold_duration_ms, got.hold_duration_ms);
        if (got.press_total != want.press_total)
          note_fault("press_total", want.press_total, got.press_total);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_clicks();
    test_noise();
    test_extremes();
    wait_drained();
    repeat (5) @(negedge clk);
    if (fault_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
